@@ rtl/sm83_alu_pkg.sv @@
// Shared definitions for the SM83 ALU: operation codes, flag bit positions
// and the decimal-adjust constants. No dependencies.
`default_nettype none

package sm83_alu_pkg;

  typedef enum logic [3:0] {
    OP_ADD      = 4'd0,
    OP_ADC      = 4'd1,
    OP_SUB      = 4'd2,
    OP_SBC      = 4'd3,
    OP_AND      = 4'd4,
    OP_XOR      = 4'd5,
    OP_OR       = 4'd6,
    OP_CP       = 4'd7,
    OP_INC8     = 4'd8,
    OP_DEC8     = 4'd9,
    OP_DAA      = 4'd10,
    OP_CPL      = 4'd11,
    OP_INC16    = 4'd12,
    OP_DEC16    = 4'd13,
    OP_ADD16    = 4'd14,
    OP_ADD_SP_E = 4'd15
  } alu_op_t;

  localparam int unsigned FLAG_Z_BIT = 3;
  localparam int unsigned FLAG_N_BIT = 2;
  localparam int unsigned FLAG_H_BIT = 1;
  localparam int unsigned FLAG_C_BIT = 0;

  localparam logic [7:0] DAA_HI_LIMIT  = 8'h99;
  localparam logic [7:0] DAA_HI_ADJ    = 8'h60;
  localparam logic [7:0] DAA_LO_ADJ    = 8'h06;
  localparam logic [3:0] DAA_LO_LIMIT  = 4'h9;

endpackage

`default_nettype wire

@@ rtl/sm83_alu_with_flags_top.sv @@
// Top level of the SM83 ALU: input register, flag and result logic, result register.
// Depends on sm83_alu_pkg.
//
// Each input beat carries one ALU operation and yields exactly one result beat.
// The block takes a new beat in every cycle while the output is not stalled; a
// beat is registered at the input, evaluated by the combinational adder and flag
// network, and held in the result register until it is read. The throughput of
// one beat per cycle holds because the input register moves on whenever the
// result register is empty or being read. The result register lets a new beat
// enter while a finished result still waits.
`default_nettype none

module sm83_alu_with_flags_top
  import sm83_alu_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [3:0]  in_op,
  input  wire logic [7:0]  in_acc,
  input  wire logic [7:0]  in_operand_byte,
  input  wire logic [15:0] in_wide_left,
  input  wire logic [15:0] in_wide_right,
  input  wire logic [3:0]  in_flags_in,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [7:0]       out_result_byte,
  output logic [15:0]      out_result_word,
  output logic [3:0]       out_flags_out
);

  logic        s1_valid_r;
  alu_op_t     op_r;
  logic [7:0]  acc_r;
  logic [7:0]  opb_r;
  logic [15:0] wl_r;
  logic [15:0] wr_r;
  logic [3:0]  fin_r;
  logic        out_valid_r;
  logic [7:0]  rb_r;
  logic [15:0] rw_r;
  logic [3:0]  fo_r;

  logic        s1_adv;
  logic        in_fire;
  logic [7:0]  rb_nxt;
  logic [15:0] rw_nxt;
  logic [3:0]  fo_nxt;

  logic        cin;
  logic        carry_t;
  logic [8:0]  sum9;
  logic [4:0]  sum_lo;
  logic [8:0]  dif9;
  logic [4:0]  dif_lo;
  logic [7:0]  inc8;
  logic [7:0]  dec8;
  logic        daa_c;
  logic [7:0]  daa_t;
  logic [7:0]  daa_r;
  logic [16:0] add16;
  logic [12:0] add16_lo;
  logic [15:0] sp_sum;
  logic [4:0]  sp_lo;
  logic [8:0]  sp_byte;

  assign s1_adv   = !out_valid_r || out_ready;
  assign in_ready = !s1_valid_r || s1_adv;
  assign in_fire  = in_valid && in_ready;

  always_comb begin
    cin     = fin_r[FLAG_C_BIT];
    carry_t = ((op_r == OP_ADC) || (op_r == OP_SBC)) ? cin : 1'b0;
    sum9    = {1'b0, acc_r} + {1'b0, opb_r} + {8'd0, carry_t};
    sum_lo  = {1'b0, acc_r[3:0]} + {1'b0, opb_r[3:0]} + {4'd0, carry_t};
    dif9    = {1'b0, acc_r} - {1'b0, opb_r} - {8'd0, carry_t};
    dif_lo  = {1'b0, acc_r[3:0]} - {1'b0, opb_r[3:0]} - {4'd0, carry_t};
    inc8    = opb_r + 8'd1;
    dec8    = opb_r - 8'd1;

    if (!fin_r[FLAG_N_BIT]) begin
      daa_c = cin || (acc_r > DAA_HI_LIMIT);
      daa_t = daa_c ? acc_r + DAA_HI_ADJ : acc_r;
      daa_r = (fin_r[FLAG_H_BIT] || (daa_t[3:0] > DAA_LO_LIMIT)) ? daa_t + DAA_LO_ADJ : daa_t;
    end else begin
      daa_c = cin;
      daa_t = cin ? acc_r - DAA_HI_ADJ : acc_r;
      daa_r = fin_r[FLAG_H_BIT] ? daa_t - DAA_LO_ADJ : daa_t;
    end

    add16    = {1'b0, wl_r} + {1'b0, wr_r};
    add16_lo = {1'b0, wl_r[11:0]} + {1'b0, wr_r[11:0]};
    sp_sum   = wr_r + {{8{opb_r[7]}}, opb_r};
    sp_lo    = {1'b0, wr_r[3:0]} + {1'b0, opb_r[3:0]};
    sp_byte  = {1'b0, wr_r[7:0]} + {1'b0, opb_r};

    rb_nxt = 8'd0;
    rw_nxt = 16'd0;
    fo_nxt = fin_r;
    case (op_r)
      OP_ADD, OP_ADC: begin
        rb_nxt = sum9[7:0];
        fo_nxt = {sum9[7:0] == 8'd0, 1'b0, sum_lo[4], sum9[8]};
      end
      OP_SUB, OP_SBC, OP_CP: begin
        rb_nxt = (op_r == OP_CP) ? acc_r : dif9[7:0];
        fo_nxt = {dif9[7:0] == 8'd0, 1'b1, dif_lo[4], dif9[8]};
      end
      OP_AND: begin
        rb_nxt = acc_r & opb_r;
        fo_nxt = {(acc_r & opb_r) == 8'd0, 1'b0, 1'b1, 1'b0};
      end
      OP_XOR: begin
        rb_nxt = acc_r ^ opb_r;
        fo_nxt = {(acc_r ^ opb_r) == 8'd0, 3'b000};
      end
      OP_OR: begin
        rb_nxt = acc_r | opb_r;
        fo_nxt = {(acc_r | opb_r) == 8'd0, 3'b000};
      end
      OP_INC8: begin
        rb_nxt = inc8;
        fo_nxt = {inc8 == 8'd0, 1'b0, opb_r[3:0] == 4'hF, cin};
      end
      OP_DEC8: begin
        rb_nxt = dec8;
        fo_nxt = {dec8 == 8'd0, 1'b1, opb_r[3:0] == 4'h0, cin};
      end
      OP_DAA: begin
        rb_nxt = daa_r;
        fo_nxt = {daa_r == 8'd0, fin_r[FLAG_N_BIT], 1'b0, daa_c};
      end
      OP_CPL: begin
        rb_nxt = ~acc_r;
        fo_nxt = {fin_r[FLAG_Z_BIT], 1'b1, 1'b1, cin};
      end
      OP_INC16: begin
        rw_nxt = wr_r + 16'd1;
      end
      OP_DEC16: begin
        rw_nxt = wr_r - 16'd1;
      end
      OP_ADD16: begin
        rw_nxt = add16[15:0];
        fo_nxt = {fin_r[FLAG_Z_BIT], 1'b0, add16_lo[12], add16[16]};
      end
      OP_ADD_SP_E: begin
        rw_nxt = sp_sum;
        fo_nxt = {1'b0, 1'b0, sp_lo[4], sp_byte[8]};
      end
      default: begin
        rb_nxt = 8'd0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_ready) begin
        s1_valid_r <= in_valid;
      end
      if (s1_adv) begin
        out_valid_r <= s1_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      op_r  <= alu_op_t'(in_op);
      acc_r <= in_acc;
      opb_r <= in_operand_byte;
      wl_r  <= in_wide_left;
      wr_r  <= in_wide_right;
      fin_r <= in_flags_in;
    end
    if (s1_adv && s1_valid_r) begin
      rb_r <= rb_nxt;
      rw_r <= rw_nxt;
      fo_r <= fo_nxt;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_result_byte = rb_r;
  assign out_result_word = rw_r;
  assign out_flags_out   = fo_r;

endmodule

`default_nettype wire

@@ rtl/sm83_alu_chk.sv @@
// Port-level checker for the SM83 ALU top level, with its bind statement.
// Depends on sm83_alu_pkg and sm83_alu_with_flags_top.
`default_nettype none

module sm83_alu_chk
  import sm83_alu_pkg::*;
(
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_valid,
  input wire logic        in_ready,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [7:0]  out_result_byte,
  input wire logic [15:0] out_result_word,
  input wire logic [3:0]  out_flags_out
);

  a_reset_clears_out: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result beat shown straight after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_result_byte)
      && $stable(out_result_word) && $stable(out_flags_out))
    else $error("stalled result beat changed");

  a_byte_word_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_result_word != 16'd0) |-> out_result_byte == 8'd0)
    else $error("byte and word results both non-zero");

  a_ready_when_drained: assert property (@(posedge clk) disable iff (!rst_n)
    out_ready |-> in_ready)
    else $error("input stalled while the output drains");

  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) ##1 out_ready |=> out_valid)
    else $error("accepted beat did not reach the output in time");

endmodule

bind sm83_alu_with_flags_top sm83_alu_chk u_sm83_alu_chk (.*);

`default_nettype wire
